FILE: rtl/prat_pkg.sv
// ----------------------------------------------------------------------------
// prat_pkg
// Shared types and constants of the pair risk alarm throttle.
// ----------------------------------------------------------------------------
package prat_pkg;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic KIND_TICK   = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  localparam logic [1:0] RISK_NORMAL  = 2'd0;
  localparam logic [1:0] RISK_WARNING = 2'd1;
  localparam logic [1:0] RISK_DANGER  = 2'd2;
  localparam logic [1:0] RISK_SATURATED = 2'd3;

  localparam logic REG_WARNING_REPEAT = 1'b0;
  localparam logic REG_DANGER_REPEAT  = 1'b1;

  localparam logic [7:0] WARNING_REPEAT_RESET = 8'd12;
  localparam logic [7:0] DANGER_REPEAT_RESET  = 8'd15;

  typedef struct packed {
    logic        kind;
    logic [6:0]  slot;
    logic [1:0]  risk;
    logic [15:0] mid_x;
    logic [15:0] mid_y;
  } cmd_t;

  typedef struct packed {
    logic [1:0] cur;
    logic [1:0] prev;
    logic [7:0] cool;
  } entry_t;

  typedef struct packed {
    logic [7:0] warning_repeat;
    logic [7:0] danger_repeat;
  } cfg_t;

  typedef struct packed {
    logic clearing;
  } back_status_t;

  typedef struct packed {
    logic [6:0]  slot;
    logic [1:0]  risk;
    logic [15:0] mid_x;
    logic [15:0] mid_y;
  } event_t;

endpackage

FILE: rtl/pair_risk_alarm_throttle.sv
// ----------------------------------------------------------------------------
// pair_risk_alarm_throttle
// Per-pair alarm throttle: a front stage, a command queue and a table engine.
// ----------------------------------------------------------------------------
// A report's event passes the queue entry, the command register and the
// output register before it shows on the result ports. The table engine
// handles a report with a memory read and a write-back of one slot, and a tick
// with one memory read and write per slot. After reset, full stays high while
// the table is cleared; configuration writes are taken.
module pair_risk_alarm_throttle import prat_pkg::*; #(
  parameter int PAIR_SLOTS = 128
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  logic                  kind_i,
  input  logic [6:0]            pair_slot_i,
  input  logic [1:0]            pair_risk_i,
  input  logic [15:0]           first_x_i,
  input  logic [15:0]           first_y_i,
  input  logic [15:0]           second_x_i,
  input  logic [15:0]           second_y_i,
  output logic                  empty,
  input  logic                  pop,
  output logic [6:0]            event_slot_o,
  output logic [1:0]            event_risk_o,
  output logic [15:0]           mid_x_o,
  output logic [15:0]           mid_y_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t         cfg_q;
  back_status_t status;
  logic         q_push;
  cmd_t         q_wr_item;
  logic         q_full;
  logic         q_pop;
  logic         q_empty;
  cmd_t         q_rd_item;
  event_t       evt;
  logic         reg_write;

  assign pready    = 1'b1;
  assign reg_write = psel & penable & pwrite & pready;
  assign prdata    = (paddr[2] == REG_DANGER_REPEAT) ? APB_DATA_W'(cfg_q.danger_repeat)
                                                     : APB_DATA_W'(cfg_q.warning_repeat);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.warning_repeat <= WARNING_REPEAT_RESET;
      cfg_q.danger_repeat  <= DANGER_REPEAT_RESET;
    end else if (reg_write) begin
      if (paddr[2] == REG_WARNING_REPEAT) begin
        cfg_q.warning_repeat <= pwdata[7:0];
      end else begin
        cfg_q.danger_repeat <= pwdata[7:0];
      end
    end
  end

  prat_front #(
    .PAIR_SLOTS(PAIR_SLOTS)
  ) u_front (
    .push        (push),
    .full        (full),
    .kind_i      (kind_i),
    .pair_slot_i (pair_slot_i),
    .pair_risk_i (pair_risk_i),
    .first_x_i   (first_x_i),
    .first_y_i   (first_y_i),
    .second_x_i  (second_x_i),
    .second_y_i  (second_y_i),
    .status_i    (status),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_item_o    (q_wr_item)
  );

  prat_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_wr_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .item_o  (q_rd_item)
  );

  prat_back #(
    .PAIR_SLOTS(PAIR_SLOTS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .status_o  (status),
    .q_empty_i (q_empty),
    .q_item_i  (q_rd_item),
    .q_pop_o   (q_pop),
    .empty     (empty),
    .pop       (pop),
    .event_o   (evt)
  );

  assign event_slot_o = evt.slot;
  assign event_risk_o = evt.risk;
  assign mid_x_o      = evt.mid_x;
  assign mid_y_o      = evt.mid_y;

endmodule

FILE: rtl/prat_front.sv
// ----------------------------------------------------------------------------
// prat_front
// Accepts input items, saturates the risk code, drops reports for slots
// outside the table and forms the coordinate midpoints.
// ----------------------------------------------------------------------------
module prat_front import prat_pkg::*; #(
  parameter int PAIR_SLOTS = 128
) (
  input  logic         push,
  output logic         full,
  input  logic         kind_i,
  input  logic [6:0]   pair_slot_i,
  input  logic [1:0]   pair_risk_i,
  input  logic [15:0]  first_x_i,
  input  logic [15:0]  first_y_i,
  input  logic [15:0]  second_x_i,
  input  logic [15:0]  second_y_i,
  input  back_status_t status_i,
  input  logic         q_full_i,
  output logic         q_push_o,
  output cmd_t         q_item_o
);

  logic        accept;
  logic        in_range;
  logic [16:0] sum_x;
  logic [16:0] sum_y;

  assign full     = q_full_i | status_i.clearing;
  assign accept   = push & ~full;
  assign in_range = 32'(pair_slot_i) < PAIR_SLOTS;
  assign q_push_o = accept & ((kind_i == KIND_TICK) | in_range);

  assign sum_x = {first_x_i[15], first_x_i} + {second_x_i[15], second_x_i};
  assign sum_y = {first_y_i[15], first_y_i} + {second_y_i[15], second_y_i};

  always_comb begin
    q_item_o.kind  = kind_i;
    q_item_o.slot  = pair_slot_i;
    q_item_o.risk  = (pair_risk_i == RISK_SATURATED) ? RISK_DANGER : pair_risk_i;
    q_item_o.mid_x = sum_x[16:1];
    q_item_o.mid_y = sum_y[16:1];
  end

endmodule

FILE: rtl/prat_queue.sv
// ----------------------------------------------------------------------------
// prat_queue
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
module prat_queue import prat_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t item_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output cmd_t item_o
);

  cmd_t       mem_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q;
  logic       do_push;
  logic       do_pop;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 2'd1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

FILE: rtl/prat_back.sv
// ----------------------------------------------------------------------------
// prat_back
// Holds the slot table in a memory, clears it after reset, sweeps it on ticks,
// performs the read-modify-write of a report and holds the result in an output register.
// ----------------------------------------------------------------------------
module prat_back import prat_pkg::*; #(
  parameter int PAIR_SLOTS = 128
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  cfg_t         cfg_i,
  output back_status_t status_o,
  input  logic         q_empty_i,
  input  cmd_t         q_item_i,
  output logic         q_pop_o,
  output logic         empty,
  input  logic         pop,
  output event_t       event_o
);

  localparam int SLOT_W = (PAIR_SLOTS > 1) ? $clog2(PAIR_SLOTS) : 1;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(PAIR_SLOTS - 1);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_EXEC  = 4'b0100,
    S_SWEEP = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  logic [SLOT_W-1:0] idx_q, idx_d;
  cmd_t              cmd_q;
  logic              cmd_load;
  entry_t            mem [PAIR_SLOTS];
  entry_t            rdata_q;
  logic              mem_we;
  logic [SLOT_W-1:0] mem_waddr;
  entry_t            mem_wdata;
  logic              mem_re;
  logic [SLOT_W-1:0] mem_raddr;
  logic              out_valid_q, out_valid_d;
  event_t            out_q;
  logic              out_load;
  logic [31:0]       q_slot_ext;
  logic [31:0]       cmd_slot_ext;
  entry_t            upd;
  logic              emit;

  assign q_slot_ext   = 32'(q_item_i.slot);
  assign cmd_slot_ext = 32'(cmd_q.slot);
  assign status_o.clearing = (state_q == S_CLEAR);
  assign empty   = ~out_valid_q;
  assign event_o = out_q;

  always_comb begin
    upd      = rdata_q;
    upd.cur  = cmd_q.risk;
    emit     = 1'b0;
    if (cmd_q.risk != RISK_NORMAL) begin
      if (rdata_q.prev == RISK_DANGER && cmd_q.risk == RISK_WARNING) begin
        upd.cool = cfg_i.warning_repeat;
      end else if (cmd_q.risk != rdata_q.prev || rdata_q.cool == 8'd0) begin
        emit     = 1'b1;
        upd.cool = (cmd_q.risk == RISK_DANGER) ? cfg_i.danger_repeat
                                               : cfg_i.warning_repeat;
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    cmd_load    = 1'b0;
    q_pop_o     = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = idx_q;
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr   = idx_q;
    out_load    = 1'b0;
    out_valid_d = out_valid_q & ~pop;
    case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
        if (idx_q == LAST_SLOT) begin
          idx_d   = '0;
          state_d = S_IDLE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o  = 1'b1;
          cmd_load = 1'b1;
          mem_re   = 1'b1;
          if (q_item_i.kind == KIND_TICK) begin
            mem_raddr = '0;
            idx_d     = '0;
            state_d   = S_SWEEP;
          end else begin
            mem_raddr = q_slot_ext[SLOT_W-1:0];
            state_d   = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        if (!(emit && out_valid_q && !pop)) begin
          mem_we    = 1'b1;
          mem_waddr = cmd_slot_ext[SLOT_W-1:0];
          mem_wdata = upd;
          state_d   = S_IDLE;
          if (emit) begin
            out_load    = 1'b1;
            out_valid_d = 1'b1;
          end
        end
      end
      S_SWEEP: begin
        mem_we         = 1'b1;
        mem_wdata.prev = rdata_q.cur;
        mem_wdata.cur  = RISK_NORMAL;
        mem_wdata.cool = (rdata_q.cool != 8'd0) ? rdata_q.cool - 8'd1 : 8'd0;
        if (idx_q == LAST_SLOT) begin
          state_d = S_IDLE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = idx_q + 1'b1;
          idx_d     = idx_q + 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_load) begin
      cmd_q <= q_item_i;
    end
    if (out_load) begin
      out_q.slot  <= cmd_q.slot;
      out_q.risk  <= cmd_q.risk;
      out_q.mid_x <= cmd_q.mid_x;
      out_q.mid_y <= cmd_q.mid_y;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

endmodule

FILE: rtl/prat_checker.sv
// ----------------------------------------------------------------------------
// prat_checker
// Port-level checks of the pair risk alarm throttle, bound to the top level.
// ----------------------------------------------------------------------------
module prat_checker import prat_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [6:0]  event_slot_o,
  input logic [1:0]  event_risk_o,
  input logic [15:0] mid_x_o,
  input logic [15:0] mid_y_o,
  input logic        pready
);

  // A waiting result is never a normal risk and never the saturated code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (event_risk_o == RISK_WARNING || event_risk_o == RISK_DANGER))
    else $error("result carries an invalid risk code");

  // A result that is not taken stays unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(event_slot_o) && $stable(event_risk_o)
                          && $stable(mid_x_o) && $stable(mid_y_o)))
    else $error("waiting result changed before it was taken");

  // The table is being cleared right after reset, so no item may enter.
  assert property (@(posedge clk_i) !rst_ni |=> full)
    else $error("input accepted during the clearing pass");

  // No result is waiting right after reset.
  assert property (@(posedge clk_i) !rst_ni |=> empty)
    else $error("result present right after reset");

  // The register port never inserts wait states.
  assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("register port stalled");

endmodule

bind pair_risk_alarm_throttle prat_checker u_prat_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .full         (full),
  .empty        (empty),
  .pop          (pop),
  .event_slot_o (event_slot_o),
  .event_risk_o (event_risk_o),
  .mid_x_o      (mid_x_o),
  .mid_y_o      (mid_y_o),
  .pready       (pready)
);
